[rtl/lpl_pkg.sv]
// lpl_pkg: shared constants, register codes and controller/datapath structs
// for the look-ahead peak limiter. No dependencies.

package lpl_pkg;

  // Sample and gain formats
  localparam int SAMPLE_BITS   = 24;            // Q1.(SAMPLE_BITS-1)
  localparam int GAIN_W        = 17;            // unsigned Q16, 65536 = 1.0
  localparam int GAIN_FRAC     = 16;
  localparam int LEN_W         = 10;            // hold_length register width
  localparam int MAX_LOOKAHEAD = 512;
  localparam int RING_DEPTH    = MAX_LOOKAHEAD + 1;
  localparam int PTR_W         = $clog2(RING_DEPTH);

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 17;

  localparam logic [CFG_IDX_W-1:0] REG_CEILING = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD    = 2'd2;

  localparam logic [GAIN_W-1:0] CEILING_RESET = 17'd65536;
  localparam logic [GAIN_W-1:0] RELEASE_RESET = 17'd20;
  localparam logic [LEN_W-1:0]  HOLD_RESET    = 10'd144;

  // Gain constants
  localparam logic [GAIN_W-1:0] UNITY_GAIN = 17'd65536;
  localparam int                SNAP_LIMIT = 65529;   // largest Q16 value <= 0.9999
  localparam int                ROUND_HALF = 1 << (GAIN_FRAC - 1);

  // peak > 1e-6 of full scale  <=>  peak > floor(2^(SAMPLE_BITS-1) / 1e6)
  localparam longint unsigned HALF_SCALE = 64'd1 << (SAMPLE_BITS - 1);
  localparam longint unsigned FLOOR_PEAK = HALF_SCALE / 64'd1000000;

  // Ceiling in sample units: ceiling << (SAMPLE_BITS-1-GAIN_FRAC)
  localparam int CEIL_SHIFT = SAMPLE_BITS - 1 - GAIN_FRAC;

  // Restoring divider: one quotient bit per cycle
  localparam int DIV_CNT_W = $clog2(GAIN_FRAC);

  // Shared multiplier operand widths
  localparam int MUL_A_W = (SAMPLE_BITS + 1 > GAIN_W + 1) ? SAMPLE_BITS + 1 : GAIN_W + 1;
  localparam int MUL_B_W = GAIN_W + 1;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // Multiplier operand select
  localparam logic [1:0] MUL_REL   = 2'd0;
  localparam logic [1:0] MUL_LEFT  = 2'd1;
  localparam logic [1:0] MUL_RIGHT = 2'd2;

  typedef struct packed {
    logic       clear_step;   // write zero at clear address, advance
    logic       capture;      // latch input transaction
    logic       peak_load;    // register peak, ring read/write, pointer advance
    logic       div_init;
    logic       div_step;
    logic       limit_apply;  // gain = min(gain, quotient), reload hold
    logic       hold_dec;
    logic       rel_add;      // release update from product
    logic       mul_en;
    logic [1:0] mul_sel;
    logic       res_l_load;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic limit_hit;
    logic hold_nz;
    logic div_last;
  } status_t;

endpackage

[rtl/lpl_ram.sv]
// lpl_ram: generic simple dual-port RAM, one write and one registered read
// port, read-first on a same-address access. No dependencies.

module lpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/lpl_ctrl.sv]
// lpl_ctrl: sequencer for the peak limiter; drives datapath commands and the
// channel handshakes. Depends on lpl_pkg.

module lpl_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  lpl_pkg::status_t status,
  output lpl_pkg::cmd_t    cmd
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_PEAK  = 4'd2;
  localparam logic [3:0] S_EVAL  = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_APPLY = 4'd5;
  localparam logic [3:0] S_REL   = 4'd6;
  localparam logic [3:0] S_MUL_L = 4'd7;
  localparam logic [3:0] S_MUL_R = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0] state;
  logic [3:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (status.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_PEAK;
        end
      end
      S_PEAK: begin
        cmd.peak_load = 1'b1;
        state_next    = S_EVAL;
      end
      S_EVAL: begin
        if (status.limit_hit) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end else if (status.hold_nz) begin
          cmd.hold_dec = 1'b1;
          state_next   = S_MUL_L;
        end else begin
          cmd.mul_en  = 1'b1;
          cmd.mul_sel = lpl_pkg::MUL_REL;
          state_next  = S_REL;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (status.div_last) begin
          state_next = S_APPLY;
        end
      end
      S_APPLY: begin
        cmd.limit_apply = 1'b1;
        state_next      = S_MUL_L;
      end
      S_REL: begin
        cmd.rel_add = 1'b1;
        state_next  = S_MUL_L;
      end
      S_MUL_L: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = lpl_pkg::MUL_LEFT;
        state_next  = S_MUL_R;
      end
      S_MUL_R: begin
        cmd.mul_en     = 1'b1;
        cmd.mul_sel    = lpl_pkg::MUL_RIGHT;
        cmd.res_l_load = 1'b1;
        state_next     = S_OUT;
      end
      S_OUT: begin
        // wait for the output register to free up
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/lpl_dp.sv]
// lpl_dp: limiter datapath: config registers, peak detect, restoring divider,
// shared multiplier, gain/hold state, ring delay and output register.
// Depends on lpl_pkg and lpl_ram.

module lpl_dp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  lpl_pkg::cmd_t                         cmd,
  output lpl_pkg::status_t                      status,
  input  logic                                  cfg_write,
  input  logic [lpl_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [lpl_pkg::CFG_W-1:0]             cfg_data,
  input  logic signed [lpl_pkg::SAMPLE_BITS-1:0] left_in,
  input  logic signed [lpl_pkg::SAMPLE_BITS-1:0] right_in,
  input  logic                                  limit_enable,
  output logic signed [lpl_pkg::SAMPLE_BITS-1:0] left_out,
  output logic signed [lpl_pkg::SAMPLE_BITS-1:0] right_out,
  output logic [lpl_pkg::GAIN_W-1:0]            gain_now
);

  localparam int SB = lpl_pkg::SAMPLE_BITS;
  localparam int GW = lpl_pkg::GAIN_W;
  localparam int GF = lpl_pkg::GAIN_FRAC;
  localparam int PW = lpl_pkg::PTR_W;

  // config registers
  logic [GW-1:0]             ceiling_gain;
  logic [GW-1:0]             release_coeff;
  logic [lpl_pkg::LEN_W-1:0] hold_length;

  // limiter state
  logic [GW-1:0] limit_gain;
  logic [PW-1:0] hold_count;
  logic [PW-1:0] write_pointer;
  logic [PW-1:0] clr_addr;

  // per-frame working registers
  logic signed [SB-1:0]    l_reg;
  logic signed [SB-1:0]    r_reg;
  logic                    en_reg;
  logic [SB-1:0]           peak;
  logic [SB-1:0]           rem;
  logic [GF-1:0]           quot;
  logic [lpl_pkg::DIV_CNT_W-1:0] div_cnt;
  logic signed [lpl_pkg::PROD_W-1:0] prod;
  logic signed [SB-1:0]    res_l;

  // combinational
  logic [PW-1:0]           eff_len;
  logic [PW-1:0]           ring_addr;
  logic [PW:0]             ring_inc;
  logic [SB-1:0]           abs_l;
  logic [SB-1:0]           abs_r;
  logic [SB-1:0]           ceil_scaled;
  logic [SB:0]             rem_shift;
  logic [SB:0]             peak_ext;
  logic [GW-1:0]           room;
  logic signed [lpl_pkg::MUL_A_W-1:0] mul_a;
  logic signed [lpl_pkg::MUL_B_W-1:0] mul_b;
  logic signed [lpl_pkg::PROD_W-1:0]  prod_rnd;
  logic [GW:0]             rel_step;
  logic [GW+1:0]           rel_sum;
  logic signed [SB-1:0]    old_l;
  logic signed [SB-1:0]    old_r;
  logic [2*SB-1:0]         ram_rdata;
  logic                    ram_we;
  logic [PW-1:0]           ram_waddr;
  logic [2*SB-1:0]         ram_wdata;

  assign eff_len = (hold_length > lpl_pkg::LEN_W'(lpl_pkg::MAX_LOOKAHEAD))
                   ? PW'(lpl_pkg::MAX_LOOKAHEAD) : PW'(hold_length);

  // pointer restarts when a shorter ring leaves it out of range
  assign ring_addr = (write_pointer > eff_len) ? '0 : write_pointer;
  assign ring_inc  = {1'b0, ring_addr} + (PW+1)'(1);

  assign abs_l = l_reg[SB-1] ? SB'(-l_reg) : SB'(l_reg);
  assign abs_r = r_reg[SB-1] ? SB'(-r_reg) : SB'(r_reg);

  assign ceil_scaled = SB'({ceiling_gain, {lpl_pkg::CEIL_SHIFT{1'b0}}});

  assign status.limit_hit  = en_reg && (peak > ceil_scaled)
                             && ({32'd0, peak} > 64'(lpl_pkg::FLOOR_PEAK));
  assign status.hold_nz    = (hold_count != '0);
  assign status.div_last   = (div_cnt == lpl_pkg::DIV_CNT_W'(GF - 1));
  assign status.clear_last = (clr_addr == PW'(lpl_pkg::RING_DEPTH - 1));

  // restoring divider step; remainder stays below peak
  assign rem_shift = {rem, 1'b0};
  assign peak_ext  = {1'b0, peak};

  // shared multiplier operands
  assign room  = lpl_pkg::UNITY_GAIN - limit_gain;
  assign old_l = ram_rdata[2*SB-1:SB];
  assign old_r = ram_rdata[SB-1:0];

  always_comb begin
    case (cmd.mul_sel)
      lpl_pkg::MUL_LEFT: begin
        mul_a = lpl_pkg::MUL_A_W'(old_l);
        mul_b = $signed({1'b0, limit_gain});
      end
      lpl_pkg::MUL_RIGHT: begin
        mul_a = lpl_pkg::MUL_A_W'(old_r);
        mul_b = $signed({1'b0, limit_gain});
      end
      default: begin
        mul_a = $signed(lpl_pkg::MUL_A_W'(room));
        mul_b = $signed({1'b0, release_coeff});
      end
    endcase
  end

  assign prod_rnd = prod + $signed(lpl_pkg::PROD_W'(lpl_pkg::ROUND_HALF));
  assign rel_step = prod_rnd[GF +: GW+1];
  assign rel_sum  = (GW+2)'(limit_gain) + (GW+2)'(rel_step);

  // ring delay memory, cleared by a sweep after reset
  assign ram_we    = cmd.clear_step || cmd.peak_load;
  assign ram_waddr = cmd.clear_step ? clr_addr : ring_addr;
  assign ram_wdata = cmd.clear_step ? '0 : {l_reg, r_reg};

  lpl_ram #(
    .WIDTH (2 * SB),
    .DEPTH (lpl_pkg::RING_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.peak_load),
    .raddr (ring_addr),
    .rdata (ram_rdata)
  );

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling_gain  <= lpl_pkg::CEILING_RESET;
      release_coeff <= lpl_pkg::RELEASE_RESET;
      hold_length   <= lpl_pkg::HOLD_RESET;
      limit_gain    <= lpl_pkg::UNITY_GAIN;
      hold_count    <= '0;
      write_pointer <= '0;
      clr_addr      <= '0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          lpl_pkg::REG_CEILING: ceiling_gain  <= cfg_data[GW-1:0];
          lpl_pkg::REG_RELEASE: release_coeff <= cfg_data[GW-1:0];
          lpl_pkg::REG_HOLD:    hold_length   <= cfg_data[lpl_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + PW'(1);
      end
      if (cmd.peak_load) begin
        write_pointer <= (ring_inc > {1'b0, eff_len}) ? '0 : ring_inc[PW-1:0];
      end
      if (cmd.limit_apply) begin
        if (GW'(quot) < limit_gain) begin
          limit_gain <= GW'(quot);
        end
        hold_count <= eff_len;
      end
      if (cmd.hold_dec) begin
        hold_count <= hold_count - PW'(1);
      end
      if (cmd.rel_add) begin
        if (rel_sum > (GW+2)'(lpl_pkg::SNAP_LIMIT)) begin
          limit_gain <= lpl_pkg::UNITY_GAIN;
        end else begin
          limit_gain <= rel_sum[GW-1:0];
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      l_reg  <= left_in;
      r_reg  <= right_in;
      en_reg <= limit_enable;
    end
    if (cmd.peak_load) begin
      peak <= (abs_r > abs_l) ? abs_r : abs_l;
    end
    if (cmd.div_init) begin
      rem     <= ceil_scaled;
      quot    <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      if (rem_shift >= peak_ext) begin
        rem  <= SB'(rem_shift - peak_ext);
        quot <= {quot[GF-2:0], 1'b1};
      end else begin
        rem  <= rem_shift[SB-1:0];
        quot <= {quot[GF-2:0], 1'b0};
      end
      div_cnt <= div_cnt + lpl_pkg::DIV_CNT_W'(1);
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.res_l_load) begin
      res_l <= prod_rnd[GF +: SB];
    end
    if (cmd.out_load) begin
      left_out  <= res_l;
      right_out <= prod_rnd[GF +: SB];
      gain_now  <= limit_gain;
    end
  end

endmodule

[rtl/lookahead_peak_limiter.sv]
// lookahead_peak_limiter: top level of the stereo look-ahead peak limiter.
// Instantiates lpl_ctrl and lpl_dp; uses lpl_pkg.
//
// Channel  | Handshake           | Payload
// ---------+---------------------+----------------------------------------
// input    | in_valid/in_ready   | left_in, right_in (s24), limit_enable
// output   | out_valid/out_ready | left_out, right_out (s24), gain_now (u17)
// config   | cfg_write           | cfg_index (2b), cfg_data (17b)
//
// Frames: one at a time. A frame that triggers gain reduction runs the
// restoring divider for ceiling/peak before its result; release and hold
// frames skip the divider. The next input transaction is taken once the
// result sits in the output register, so a stalled output costs at most
// one frame of slack.
// Reset: synchronous; afterwards a clearing pass zeroes the whole delay
// RAM, one entry per cycle, with in_ready low (config writes still taken).

module lookahead_peak_limiter (
  input  logic                                   clk,
  input  logic                                   rst,
  // configuration
  input  logic                                   cfg_write,
  input  logic [lpl_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [lpl_pkg::CFG_W-1:0]              cfg_data,
  // input frames
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic signed [lpl_pkg::SAMPLE_BITS-1:0] left_in,
  input  logic signed [lpl_pkg::SAMPLE_BITS-1:0] right_in,
  input  logic                                   limit_enable,
  // output frames
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic signed [lpl_pkg::SAMPLE_BITS-1:0] left_out,
  output logic signed [lpl_pkg::SAMPLE_BITS-1:0] right_out,
  output logic [lpl_pkg::GAIN_W-1:0]             gain_now
);

  // Controller sequences each frame: capture, peak + ring access, decision,
  // then divider (limit), multiply-add (release) or hold decrement, then two
  // passes through the shared multiplier for the delayed samples.
  lpl_pkg::cmd_t    cmd;
  lpl_pkg::status_t status;

  lpl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Datapath holds all gain/hold state, the config registers, the delay
  // RAM and the output payload register.
  lpl_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .left_in      (left_in),
    .right_in     (right_in),
    .limit_enable (limit_enable),
    .left_out     (left_out),
    .right_out    (right_out),
    .gain_now     (gain_now)
  );

endmodule

[rtl/lpl_checker.sv]
// lpl_checker: port-level assertions for lookahead_peak_limiter, bound to
// the top level below. Uses lpl_pkg.

module lpl_checker (
  input logic                                   clk,
  input logic                                   rst,
  input logic                                   in_valid,
  input logic                                   in_ready,
  input logic                                   out_valid,
  input logic                                   out_ready,
  input logic signed [lpl_pkg::SAMPLE_BITS-1:0] left_out,
  input logic signed [lpl_pkg::SAMPLE_BITS-1:0] right_out,
  input logic [lpl_pkg::GAIN_W-1:0]             gain_now
);

  // frames accepted but not yet delivered
  logic [1:0] pending;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (in_acc && !out_acc) begin
      pending <= pending + 2'd1;
    end else if (out_acc && !in_acc) begin
      pending <= pending - 2'd1;
    end
  end

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(left_out)
                                && $stable(right_out) && $stable(gain_now))
    else $error("output transaction changed while stalled");

  // no result without a frame behind it
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pending != 2'd0)
    else $error("output transaction with no pending input");

  // at most one frame in work plus one in the output register
  a_depth: assert property (@(posedge clk) disable iff (rst)
    pending != 2'd3)
    else $error("too many frames in flight");

  // one frame at a time: input closes after a transaction
  a_one_frame: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> !in_ready)
    else $error("input taken on consecutive cycles");

  a_gain_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> gain_now <= lpl_pkg::UNITY_GAIN)
    else $error("gain above unity");

endmodule

bind lookahead_peak_limiter lpl_checker u_lpl_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .left_out  (left_out),
  .right_out (right_out),
  .gain_now  (gain_now)
);
